>>> sv/aiff_pkg.sv
// Shared constants and record types of the AIFF stream parser.
package aiff_pkg;

  // Chunk and header tags, big-endian ASCII
  localparam logic [31:0] TAG_FORM = 32'h464F524D;
  localparam logic [31:0] TAG_AIFF = 32'h41494646;
  localparam logic [31:0] TAG_COMM = 32'h434F4D4D;
  localparam logic [31:0] TAG_SSND = 32'h53534E44;

  // Header walk: index of last FORM byte and last header byte
  localparam int FORM_TAG_LAST = 3;
  localparam int FORM_LAST     = 11;
  localparam int CHDR_TAG_LAST = 3;
  localparam int CHDR_LAST     = 7;

  // COMM body layout
  localparam int COMM_FIELDS_LAST = 7;
  localparam int COMM_EXP_FIRST   = 8;
  localparam int COMM_EXP_LAST    = 9;
  localparam int COMM_MIN         = 18;

  // SSND body layout: 4-byte offset, then 4-byte block size
  localparam int SSND_OFS_BYTES = 4;
  localparam int SSND_PREAMBLE  = 8;

  // 80-bit extended float to integer Hz
  localparam int             EXP_BIAS      = 16383;
  localparam int             RIGHT_BASE    = EXP_BIAS + 63;
  localparam int             SAT_EXP       = RIGHT_BASE + 31;
  localparam int             ZERO_EXP      = RIGHT_BASE - 64;
  localparam logic [7:0]     EXP_HIGH_MASK = 8'h7F;
  localparam logic [7:0]     SIGN_MASK     = 8'h80;
  localparam logic [30:0]    MAX31         = 31'h7FFFFFFF;

  // Committed COMM values after reset
  localparam logic [15:0] CHANNELS_RST  = 16'd1;
  localparam logic [15:0] BITS_RST      = 16'd16;
  localparam logic [15:0] BITS_REQUIRED = 16'd16;

  localparam int QUEUE_DEPTH = 8;

  // Per-byte record from the parser, rate still in raw extended form
  typedef struct packed {
    logic        has_sample;
    logic [15:0] sample;
    logic        first;
    logic        has_status;
    logic        valid_part;
    logic [15:0] channels;
    logic [15:0] bits;
    logic [30:0] total;
    logic [15:0] rate_se;
    logic [63:0] rate_mant;
  } front_rec_t;

  // Per-byte record with the rate converted, as queued for output
  typedef struct packed {
    logic        has_sample;
    logic [15:0] sample;
    logic        first;
    logic        has_status;
    logic        valid;
    logic [30:0] rate;
    logic [15:0] channels;
    logic [15:0] bits;
    logic [30:0] total;
  } back_rec_t;

endpackage

>>> sv/aiff_stream_parser.sv
// Top level of the AIFF stream parser: parser front, rate unit, result queue.
//
//   channel | signals                                   | request carries
//   --------+-------------------------------------------+------------------------------
//   in      | in_valid, in_ready, in_byte, end_of_file   | one file byte
//   out     | out_valid, out_ready, is_status, ...       | one sample or status result
//
// One byte is taken per clock while the queue has room. A byte that completes a
// sample passes the rate stages and the queue into the output register; the final byte
// of a file that also completes a sample gives a sample result and then a status result.
// Throughput is set by the queue depth against the path through the rate stages and
// the output register. Reset is synchronous and clears the parser, the rate stages and
// the queue; a stalled output only stops input once the queue fills.
module aiff_stream_parser #(
  parameter int QueueDepth = aiff_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               end_of_file,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_status,
  output logic signed [15:0] pcm_sample,
  output logic               first_of_chunk,
  output logic               file_valid,
  output logic [30:0]        sample_rate,
  output logic signed [15:0] channel_count,
  output logic signed [15:0] bits_per_sample,
  output logic [30:0]        sample_total
);

  logic                 room;
  logic                 rec_valid;
  aiff_pkg::front_rec_t rec;
  logic                 conv_valid;
  aiff_pkg::back_rec_t  conv_rec;
  logic [1:0]           inflight;

  aiff_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .end_of_file (end_of_file),
    .room        (room),
    .rec_valid   (rec_valid),
    .rec         (rec)
  );

  aiff_rate u_rate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rec_valid),
    .in_rec    (rec),
    .out_valid (conv_valid),
    .out_rec   (conv_rec),
    .inflight  (inflight)
  );

  aiff_back #(
    .Depth (QueueDepth)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .push            (conv_valid),
    .push_rec        (conv_rec),
    .inflight        (inflight),
    .room            (room),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .is_status       (is_status),
    .pcm_sample      (pcm_sample),
    .first_of_chunk  (first_of_chunk),
    .file_valid      (file_valid),
    .sample_rate     (sample_rate),
    .channel_count   (channel_count),
    .bits_per_sample (bits_per_sample),
    .sample_total    (sample_total)
  );

endmodule

>>> sv/aiff_front.sv
// Byte-serial AIFF chunk walker: header check, COMM capture, SSND sample assembly.
module aiff_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                end_of_file,
  input  logic                room,
  output logic                rec_valid,
  output aiff_pkg::front_rec_t rec
);

  typedef enum logic [4:0] {
    PH_FORM = 5'b00001,
    PH_CHDR = 5'b00010,
    PH_BODY = 5'b00100,
    PH_PAD  = 5'b01000,
    PH_DEAD = 5'b10000
  } phase_t;

  phase_t      phase, phase_next;
  logic        header_ok, header_ok_next;
  logic [3:0]  hdr_idx, hdr_idx_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] body_pos, body_pos_next;
  logic [63:0] comm_scratch, comm_scratch_next;
  logic [15:0] rate_exponent, rate_exponent_next;
  logic [31:0] comm_fields, comm_fields_next;
  logic [15:0] saved_channels, saved_channels_next;
  logic [15:0] saved_bits, saved_bits_next;
  logic [15:0] saved_se, saved_se_next;
  logic [63:0] saved_mant, saved_mant_next;
  logic        seen_common, seen_common_next;
  logic        seen_data, seen_data_next;
  logic [31:0] data_offset, data_offset_next;
  logic [8:0]  pending, pending_next;
  logic [30:0] chunk_count, chunk_count_next;
  logic [30:0] kept_count, kept_count_next;

  logic        accept;
  logic        emit;
  logic        emit_first;
  logic [15:0] emit_sample;

  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  // Next-state decode for one byte
  always_comb begin
    logic [30:0] count_base;
    logic [32:0] pos_inc;
    phase_next          = phase;
    header_ok_next      = header_ok;
    hdr_idx_next        = hdr_idx;
    chunk_tag_next      = chunk_tag;
    chunk_length_next   = chunk_length;
    body_pos_next       = body_pos;
    comm_scratch_next   = comm_scratch;
    rate_exponent_next  = rate_exponent;
    comm_fields_next    = comm_fields;
    saved_channels_next = saved_channels;
    saved_bits_next     = saved_bits;
    saved_se_next       = saved_se;
    saved_mant_next     = saved_mant;
    seen_common_next    = seen_common;
    seen_data_next      = seen_data;
    data_offset_next    = data_offset;
    pending_next        = pending;
    chunk_count_next    = chunk_count;
    kept_count_next     = kept_count;
    emit                = 1'b0;
    emit_first          = 1'b0;
    emit_sample         = {pending[7:0], in_byte};
    count_base          = chunk_count;
    pos_inc             = {1'b0, body_pos} + 33'd1;

    case (phase)
      PH_FORM: begin
        chunk_tag_next = {chunk_tag[23:0], in_byte};
        if (hdr_idx == 4'(aiff_pkg::FORM_TAG_LAST) && chunk_tag_next != aiff_pkg::TAG_FORM) begin
          phase_next   = PH_DEAD;
          hdr_idx_next = hdr_idx + 4'd1;
        end else if (hdr_idx == 4'(aiff_pkg::FORM_LAST)) begin
          if (chunk_tag_next == aiff_pkg::TAG_AIFF) begin
            header_ok_next = 1'b1;
            phase_next     = PH_CHDR;
          end else begin
            phase_next = PH_DEAD;
          end
          hdr_idx_next = 4'd0;
        end else begin
          hdr_idx_next = hdr_idx + 4'd1;
        end
      end
      PH_CHDR: begin
        if (hdr_idx <= 4'(aiff_pkg::CHDR_TAG_LAST)) begin
          chunk_tag_next = {chunk_tag[23:0], in_byte};
        end else begin
          chunk_length_next = {chunk_length[23:0], in_byte};
        end
        if (hdr_idx >= 4'(aiff_pkg::CHDR_LAST)) begin
          hdr_idx_next       = 4'd0;
          body_pos_next      = 32'd0;
          pending_next       = 9'd0;
          comm_scratch_next  = 64'd0;
          rate_exponent_next = 16'd0;
          data_offset_next   = 32'd0;
          phase_next         = (chunk_length_next == 32'd0) ? PH_CHDR : PH_BODY;
        end else begin
          hdr_idx_next = hdr_idx + 4'd1;
        end
      end
      PH_BODY: begin
        if (chunk_tag == aiff_pkg::TAG_COMM) begin
          // header fields, then exponent, then mantissa
          if (body_pos < 32'(aiff_pkg::COMM_EXP_FIRST)) begin
            comm_scratch_next = {comm_scratch[55:0], in_byte};
          end
          if (body_pos == 32'(aiff_pkg::COMM_FIELDS_LAST)) begin
            comm_fields_next = {comm_scratch_next[63:48], comm_scratch_next[15:0]};
          end
          if (body_pos == 32'(aiff_pkg::COMM_EXP_FIRST) ||
              body_pos == 32'(aiff_pkg::COMM_EXP_LAST)) begin
            rate_exponent_next = {rate_exponent[7:0], in_byte};
          end
          if (body_pos > 32'(aiff_pkg::COMM_EXP_LAST) &&
              body_pos < 32'(aiff_pkg::COMM_MIN)) begin
            comm_scratch_next = {comm_scratch[55:0], in_byte};
          end
          if (body_pos == 32'(aiff_pkg::COMM_MIN - 1)) begin
            saved_channels_next = comm_fields[31:16];
            saved_bits_next     = comm_fields[15:0];
            saved_se_next       = rate_exponent;
            saved_mant_next     = comm_scratch_next;
            seen_common_next    = 1'b1;
          end
        end else if (chunk_tag == aiff_pkg::TAG_SSND) begin
          if (body_pos < 32'(aiff_pkg::SSND_OFS_BYTES)) begin
            data_offset_next = {data_offset[23:0], in_byte};
          end else if (body_pos >= 32'(aiff_pkg::SSND_PREAMBLE) &&
                       (body_pos - 32'(aiff_pkg::SSND_PREAMBLE)) >= data_offset) begin
            // first data byte opens a new kept chunk
            if ((body_pos - 32'(aiff_pkg::SSND_PREAMBLE)) == data_offset) begin
              seen_data_next   = 1'b1;
              count_base       = 31'd0;
              chunk_count_next = 31'd0;
              kept_count_next  = 31'd0;
            end
            if (!pending[8]) begin
              pending_next = {1'b1, in_byte};
            end else begin
              emit             = 1'b1;
              emit_first       = (count_base == 31'd0);
              pending_next     = 9'd0;
              chunk_count_next = count_base + 31'd1;
              kept_count_next  = count_base + 31'd1;
            end
          end
        end
        body_pos_next = pos_inc[31:0];
        if (pos_inc >= {1'b0, chunk_length}) begin
          phase_next = chunk_length[0] ? PH_PAD : PH_CHDR;
        end
      end
      PH_PAD: begin
        phase_next = PH_CHDR;
      end
      default: begin
      end
    endcase
  end

  // Record towards the rate unit
  always_comb begin
    rec            = '0;
    rec.has_sample = emit;
    rec.sample     = emit ? emit_sample : 16'd0;
    rec.first      = emit_first;
    rec.has_status = end_of_file;
    rec.valid_part = header_ok_next && seen_common_next && seen_data_next &&
                     saved_bits_next == aiff_pkg::BITS_REQUIRED &&
                     !saved_channels_next[15] && saved_channels_next != 16'd0 &&
                     kept_count_next != 31'd0;
    rec.channels   = saved_channels_next;
    rec.bits       = saved_bits_next;
    rec.total      = kept_count_next;
    rec.rate_se    = saved_se_next;
    rec.rate_mant  = saved_mant_next;
  end

  assign rec_valid = accept && (emit || end_of_file);

  // Parser state; a status request starts the next file from reset
  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_file)) begin
      phase          <= PH_FORM;
      header_ok      <= 1'b0;
      hdr_idx        <= 4'd0;
      chunk_tag      <= 32'd0;
      chunk_length   <= 32'd0;
      body_pos       <= 32'd0;
      comm_scratch   <= 64'd0;
      rate_exponent  <= 16'd0;
      comm_fields    <= 32'd0;
      saved_channels <= aiff_pkg::CHANNELS_RST;
      saved_bits     <= aiff_pkg::BITS_RST;
      saved_se       <= 16'd0;
      saved_mant     <= 64'd0;
      seen_common    <= 1'b0;
      seen_data      <= 1'b0;
      data_offset    <= 32'd0;
      pending        <= 9'd0;
      chunk_count    <= 31'd0;
      kept_count     <= 31'd0;
    end else if (accept) begin
      phase          <= phase_next;
      header_ok      <= header_ok_next;
      hdr_idx        <= hdr_idx_next;
      chunk_tag      <= chunk_tag_next;
      chunk_length   <= chunk_length_next;
      body_pos       <= body_pos_next;
      comm_scratch   <= comm_scratch_next;
      rate_exponent  <= rate_exponent_next;
      comm_fields    <= comm_fields_next;
      saved_channels <= saved_channels_next;
      saved_bits     <= saved_bits_next;
      saved_se       <= saved_se_next;
      saved_mant     <= saved_mant_next;
      seen_common    <= seen_common_next;
      seen_data      <= seen_data_next;
      data_offset    <= data_offset_next;
      pending        <= pending_next;
      chunk_count    <= chunk_count_next;
      kept_count     <= kept_count_next;
    end
  end

endmodule

>>> sv/aiff_rate.sv
// Two-stage conversion of the extended-float rate to rounded integer Hz.
module aiff_rate (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  aiff_pkg::front_rec_t in_rec,
  output logic                 out_valid,
  output aiff_pkg::back_rec_t  out_rec,
  output logic [1:0]           inflight
);

  typedef struct packed {
    logic        has_sample;
    logic [15:0] sample;
    logic        first;
    logic        has_status;
    logic        valid_part;
    logic [15:0] channels;
    logic [15:0] bits;
    logic [30:0] total;
    logic        zero;
    logic        left;
    logic        sat;
    logic [30:0] left_val;
    logic [63:0] coarse;
    logic [2:0]  fine;
  } stage_t;

  stage_t      s1, s1_next;
  logic        v1;
  logic        v2;

  logic [14:0] ex;
  logic [15:0] exw;
  logic        neg;
  logic [4:0]  lsh;
  logic [5:0]  rsh;
  logic [61:0] prod;
  logic [15:0] lsh_full;
  logic [15:0] rsh_full;

  // Stage 1: classify, left shift, coarse right shift by bytes
  always_comb begin
    ex       = {in_rec.rate_se[14:8] & aiff_pkg::EXP_HIGH_MASK[6:0], in_rec.rate_se[7:0]};
    exw      = {1'b0, ex};
    neg      = |(in_rec.rate_se[15:8] & aiff_pkg::SIGN_MASK);
    lsh_full = exw - 16'(aiff_pkg::RIGHT_BASE);
    rsh_full = 16'(aiff_pkg::RIGHT_BASE - 1) - exw;
    lsh      = lsh_full[4:0];
    rsh      = rsh_full[5:0];
    prod     = {31'd0, in_rec.rate_mant[30:0]} << lsh;

    s1_next.has_sample = in_rec.has_sample;
    s1_next.sample     = in_rec.sample;
    s1_next.first      = in_rec.first;
    s1_next.has_status = in_rec.has_status;
    s1_next.valid_part = in_rec.valid_part;
    s1_next.channels   = in_rec.channels;
    s1_next.bits       = in_rec.bits;
    s1_next.total      = in_rec.total;
    s1_next.zero       = neg || in_rec.rate_mant == 64'd0 ||
                         exw < 16'(aiff_pkg::ZERO_EXP);
    s1_next.left       = exw >= 16'(aiff_pkg::RIGHT_BASE);
    s1_next.sat        = exw >= 16'(aiff_pkg::SAT_EXP) || (|in_rec.rate_mant[63:31]) ||
                         (|prod[61:31]);
    s1_next.left_val   = prod[30:0];
    s1_next.coarse     = in_rec.rate_mant >> {rsh[5:3], 3'b000};
    s1_next.fine       = rsh[2:0];
  end

  // Stage 2: fine shift, round half up, saturate
  logic [63:0]        t;
  logic [31:0]        q;
  logic               right_sat;
  logic [30:0]        rate;
  aiff_pkg::back_rec_t s2_next;

  always_comb begin
    t         = s1.coarse >> s1.fine;
    q         = {1'b0, t[31:1]} + {31'd0, t[0]};
    right_sat = (|t[63:32]) || q[31];
    if (s1.zero) begin
      rate = 31'd0;
    end else if (s1.left) begin
      rate = s1.sat ? aiff_pkg::MAX31 : s1.left_val;
    end else begin
      rate = right_sat ? aiff_pkg::MAX31 : q[30:0];
    end

    s2_next.has_sample = s1.has_sample;
    s2_next.sample     = s1.sample;
    s2_next.first      = s1.first;
    s2_next.has_status = s1.has_status;
    s2_next.valid      = s1.valid_part && rate != 31'd0;
    s2_next.rate       = rate;
    s2_next.channels   = s1.channels;
    s2_next.bits       = s1.bits;
    s2_next.total      = s1.total;
  end

  // Stages never stall; room is reserved before a byte is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    s1      <= s1_next;
    out_rec <= s2_next;
  end

  assign out_valid = v2;
  assign inflight  = {1'b0, v1} + {1'b0, v2};

endmodule

>>> sv/aiff_back.sv
// Record queue and output register; splits a record into sample and status results.
module aiff_back #(
  parameter int Depth = aiff_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  aiff_pkg::back_rec_t push_rec,
  input  logic [1:0]          inflight,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                is_status,
  output logic signed [15:0]  pcm_sample,
  output logic                first_of_chunk,
  output logic                file_valid,
  output logic [30:0]         sample_rate,
  output logic signed [15:0]  channel_count,
  output logic signed [15:0]  bits_per_sample,
  output logic [30:0]         sample_total
);

  localparam int IdxW = (Depth > 2) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  aiff_pkg::back_rec_t mem [Depth];
  logic [IdxW-1:0]     wr_ptr;
  logic [IdxW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic                sample_done;

  aiff_pkg::back_rec_t head;
  logic                load;
  logic                pop;
  logic                take_sample;
  logic [CntW+1:0]     reserved;

  assign head        = mem[rd_ptr];
  assign load        = (!out_valid || out_ready) && count != '0;
  assign take_sample = head.has_sample && !sample_done;
  assign pop         = load && !(take_sample && head.has_status);

  // Space for the request about to be taken plus records still in the rate stages
  assign reserved = {2'b00, count} + {{CntW{1'b0}}, inflight};
  assign room     = reserved < (CntW + 2)'(Depth);

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      count       <= '0;
      sample_done <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IdxW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IdxW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(push) - CntW'(pop);
      if (load) begin
        sample_done <= !pop;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (take_sample) begin
        is_status       <= 1'b0;
        pcm_sample      <= head.sample;
        first_of_chunk  <= head.first;
        file_valid      <= 1'b0;
        sample_rate     <= 31'd0;
        channel_count   <= 16'sd0;
        bits_per_sample <= 16'sd0;
        sample_total    <= 31'd0;
      end else begin
        is_status       <= 1'b1;
        pcm_sample      <= 16'sd0;
        first_of_chunk  <= 1'b0;
        file_valid      <= head.valid;
        sample_rate     <= head.rate;
        channel_count   <= head.channels;
        bits_per_sample <= head.bits;
        sample_total    <= head.total;
      end
    end
  end

endmodule

>>> dv/aiff_result_checker.sv
// Checker for the AIFF stream parser: tracks the file byte by byte and checks every result.
`timescale 1ns / 1ps

module aiff_result_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               end_of_file,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               is_status,
  input  logic signed [15:0] pcm_sample,
  input  logic               first_of_chunk,
  input  logic               file_valid,
  input  logic [30:0]        sample_rate,
  input  logic signed [15:0] channel_count,
  input  logic signed [15:0] bits_per_sample,
  input  logic [30:0]        sample_total,
  output int                 fail_count,
  output int                 open_results,
  output int                 samples_seen,
  output int                 files_seen
);
  import aiff_pkg::*;

  typedef enum logic [2:0] {
    WALK_FORM, WALK_CHUNK_HDR, WALK_BODY, WALK_PAD, WALK_DEAD
  } walk_t;

  typedef struct packed {
    logic        is_status;
    logic [15:0] sample;
    logic        first;
    logic        valid;
    logic [30:0] rate;
    logic [15:0] channels;
    logic [15:0] sample_bits;
    logic [30:0] total;
  } result_t;

  // Parser view of the file so far
  walk_t       walk;
  logic        header_ok;
  int          hdr_idx;
  logic [31:0] tag;
  logic [31:0] chunk_len;
  logic [63:0] body_pos;
  logic [63:0] comm_acc;
  logic [15:0] rate_se;
  logic [31:0] comm_fields;
  logic [15:0] chans;
  logic [15:0] sample_bits;
  logic [30:0] rate_hz;
  logic        seen_comm;
  logic        seen_ssnd;
  logic [31:0] ssnd_offset;
  logic [8:0]  high_byte;
  logic [30:0] run_count;
  logic [30:0] kept_count;

  result_t due_results[$];
  result_t got;
  result_t want;

  // Extended float to whole Hz, rounded half away from zero, saturating
  function automatic logic [30:0] ext_to_hz(input logic [15:0] se, input logic [63:0] m);
    int          e;
    int          s;
    logic [63:0] q;
    if (se[15] || m == 64'd0) return 31'd0;
    e = int'(se[14:0]) - EXP_BIAS - 63;
    if (e >= 0) begin
      if (e >= 31 || m > (64'(MAX31) >> e)) return MAX31;
      q = m << e;
      return q[30:0];
    end
    s = -e;
    if (s >= 65) return 31'd0;
    q = (s >= 64) ? 64'd0 : (m >> s);
    q = q + 64'(m[s-1]);
    return (q > 64'(MAX31)) ? MAX31 : q[30:0];
  endfunction

  function automatic string rec_text(input result_t r);
    return $sformatf("status=%0b sample=%0d first=%0b valid=%0b rate=%0d chans=%0d bits=%0d total=%0d",
                     r.is_status, $signed(r.sample), r.first, r.valid, r.rate,
                     $signed(r.channels), $signed(r.sample_bits), r.total);
  endfunction

  task automatic note_failure(input string msg);
    if (fail_count < 10) $display("[%0t] %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_parser();
    walk        = WALK_FORM;
    header_ok   = 1'b0;
    hdr_idx     = 0;
    tag         = '0;
    chunk_len   = '0;
    body_pos    = '0;
    comm_acc    = '0;
    rate_se     = '0;
    comm_fields = '0;
    chans       = CHANNELS_RST;
    sample_bits = BITS_RST;
    rate_hz     = '0;
    seen_comm   = 1'b0;
    seen_ssnd   = 1'b0;
    ssnd_offset = '0;
    high_byte   = '0;
    run_count   = '0;
    kept_count  = '0;
  endtask

  // One body byte of a COMM or SSND chunk
  task automatic body_byte(input logic [7:0] b);
    logic [63:0] rel;
    result_t     r;
    if (tag == TAG_COMM) begin
      if (body_pos < 8) comm_acc = {comm_acc[55:0], b};
      if (body_pos == COMM_FIELDS_LAST) comm_fields = {comm_acc[63:48], comm_acc[15:0]};
      if (body_pos == COMM_EXP_FIRST || body_pos == COMM_EXP_LAST) rate_se = {rate_se[7:0], b};
      if (body_pos > COMM_EXP_LAST && body_pos < COMM_MIN) comm_acc = {comm_acc[55:0], b};
      if (body_pos == COMM_MIN - 1) begin
        chans       = comm_fields[31:16];
        sample_bits = comm_fields[15:0];
        rate_hz     = ext_to_hz(rate_se, comm_acc);
        seen_comm   = 1'b1;
      end
    end else if (tag == TAG_SSND) begin
      rel = body_pos - SSND_PREAMBLE;
      if (body_pos < SSND_OFS_BYTES) begin
        ssnd_offset = {ssnd_offset[23:0], b};
      end else if (body_pos >= SSND_PREAMBLE && rel >= {32'd0, ssnd_offset}) begin
        // first data byte opens a new kept chunk
        if (rel == {32'd0, ssnd_offset}) begin
          seen_ssnd  = 1'b1;
          run_count  = '0;
          kept_count = '0;
        end
        if (!high_byte[8]) begin
          high_byte = {1'b1, b};
        end else begin
          r          = '0;
          r.sample   = {high_byte[7:0], b};
          r.first    = (run_count == 0);
          due_results.push_back(r);
          high_byte  = '0;
          run_count  = run_count + 31'd1;
          kept_count = run_count;
        end
      end
    end
  endtask

  // Advance the parser by one accepted byte and queue what it causes
  task automatic parse_byte(input logic [7:0] b, input logic eof);
    result_t r;
    case (walk)
      WALK_FORM: begin
        tag = {tag[23:0], b};
        if (hdr_idx == FORM_LAST) begin
          if (tag == TAG_AIFF) begin
            header_ok = 1'b1;
            walk      = WALK_CHUNK_HDR;
          end else begin
            walk = WALK_DEAD;
          end
          hdr_idx = 0;
        end else begin
          if (hdr_idx == FORM_TAG_LAST && tag != TAG_FORM) walk = WALK_DEAD;
          hdr_idx++;
        end
      end
      WALK_CHUNK_HDR: begin
        if (hdr_idx <= CHDR_TAG_LAST) tag = {tag[23:0], b};
        else chunk_len = {chunk_len[23:0], b};
        if (hdr_idx >= CHDR_LAST) begin
          hdr_idx     = 0;
          body_pos    = '0;
          high_byte   = '0;
          comm_acc    = '0;
          rate_se     = '0;
          ssnd_offset = '0;
          walk        = (chunk_len == 0) ? WALK_CHUNK_HDR : WALK_BODY;
        end else begin
          hdr_idx++;
        end
      end
      WALK_BODY: begin
        body_byte(b);
        body_pos++;
        if (body_pos >= {32'd0, chunk_len}) walk = chunk_len[0] ? WALK_PAD : WALK_CHUNK_HDR;
      end
      WALK_PAD: walk = WALK_CHUNK_HDR;
      default: ;
    endcase

    // last byte of the file: status record, then a fresh parser
    if (eof) begin
      r             = '0;
      r.is_status   = 1'b1;
      r.valid       = header_ok && seen_comm && seen_ssnd && sample_bits == BITS_REQUIRED &&
                      rate_hz != 0 && !chans[15] && chans != 0 && kept_count != 0;
      r.rate        = rate_hz;
      r.channels    = chans;
      r.sample_bits = sample_bits;
      r.total       = kept_count;
      due_results.push_back(r);
      clear_parser();
    end
  endtask

  // Compare each output request with the oldest prediction, then predict new input
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.is_status   = is_status;
        got.sample      = pcm_sample;
        got.first       = first_of_chunk;
        got.valid       = file_valid;
        got.rate        = sample_rate;
        got.channels    = channel_count;
        got.sample_bits = bits_per_sample;
        got.total       = sample_total;
        if (due_results.size() == 0) begin
          note_failure({"unexpected result: ", rec_text(got)});
        end else begin
          want = due_results.pop_front();
          if (got !== want)
            note_failure({"mismatch\n  expected ", rec_text(want), "\n  actual   ", rec_text(got)});
          if (want.is_status) files_seen++;
          else samples_seen++;
        end
      end
      if (in_valid && in_ready) parse_byte(in_byte, end_of_file);
    end
    open_results = due_results.size();
  end

endmodule

>>> dv/testbench.sv
// Top of the AIFF stream parser testbench: clock, reset, file stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import aiff_pkg::*;

  localparam int    HOLD_CYCLES  = 300;
  localparam int    RANDOM_BYTES = 400;
  localparam int    QUIET_AFTER  = 300;
  localparam longint LIMIT_NS    = 2_000_000;

  logic               clk;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic [7:0]         in_byte     = 8'd0;
  logic               end_of_file = 1'b0;
  logic               out_ready   = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic               is_status;
  logic signed [15:0] pcm_sample;
  logic               first_of_chunk;
  logic               file_valid;
  logic [30:0]        sample_rate;
  logic signed [15:0] channel_count;
  logic signed [15:0] bits_per_sample;
  logic [30:0]        sample_total;

  int fail_count;
  int open_results;
  int samples_seen;
  int files_seen;
  int bytes_sent;

  // Idling control: quiet stops all idling, calm stops sender gaps only
  bit quiet        = 1'b0;
  bit calm         = 1'b0;
  bit hold_request = 1'b0;

  logic [7:0] file_bytes[$];

  aiff_stream_parser dut (.*);
  aiff_result_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAIL aiff_stream_parser");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // File building
  task automatic put_noise(input int n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(w[i*8 +: 8]);
  endtask

  task automatic put_half(input logic [15:0] h);
    file_bytes.push_back(h[15:8]);
    file_bytes.push_back(h[7:0]);
  endtask

  task automatic put_header(input logic [31:0] form_tag, input logic [31:0] kind_tag);
    put_word(form_tag);
    put_word($urandom);
    put_word(kind_tag);
  endtask

  // COMM chunk; a body shorter than 18 bytes is cut from the full layout, a longer one filled with noise
  task automatic put_comm(input int body_len, input logic [15:0] chans,
                          input logic [15:0] sample_size, input logic [15:0] se,
                          input logic [63:0] mant);
    int start;
    put_word(TAG_COMM);
    put_word(32'(body_len));
    start = file_bytes.size();
    put_half(chans);
    put_word($urandom);
    put_half(sample_size);
    put_half(se);
    put_word(mant[63:32]);
    put_word(mant[31:0]);
    while (file_bytes.size() > start + body_len) void'(file_bytes.pop_back());
    if (file_bytes.size() < start + body_len) put_noise(start + body_len - file_bytes.size());
    if (body_len % 2 == 1) put_noise(1);
  endtask

  task automatic put_ssnd(input int offset, input int data_len);
    int len;
    len = SSND_PREAMBLE + offset + data_len;
    put_word(TAG_SSND);
    put_word(32'(len));
    put_word(32'(offset));
    put_word($urandom);
    put_noise(offset + data_len + len % 2);
  endtask

  task automatic put_other(input int len);
    logic [31:0] t;
    do t = $urandom; while (t == TAG_COMM || t == TAG_SSND);
    put_word(t);
    put_word(32'(len));
    put_noise(len + len % 2);
  endtask

  // One input request per byte; optional gap before it
  task automatic push_byte(input logic [7:0] b, input logic last);
    if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_byte     <= b;
    end_of_file <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_file(input int keep);
    for (int i = 0; i < keep; i++) push_byte(file_bytes[i], i == keep - 1);
    file_bytes.delete();
  endtask

  task automatic pick_rate(output logic [15:0] se, output logic [63:0] mant);
    mant = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: begin
        se   = 16'h400E;
        mant = 64'hAC44_0000_0000_0000;
      end
      1, 2, 3, 4: begin
        se      = 16'(EXP_BIAS + $urandom_range(0, 34));
        mant[63] = 1'b1;
      end
      5: se = 16'h8000 | 16'($urandom);
      6: begin
        se   = 16'($urandom);
        mant = 64'd0;
      end
      7: se = 16'h7FFF;
      8: se = 16'(EXP_BIAS - $urandom_range(1, 70));
      default: se = 16'($urandom);
    endcase
  endtask

  function automatic logic [15:0] pick_channels();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'h8000 | 16'($urandom);
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [15:0] pick_bits();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(1, 32));
      default: return 16'd16;
    endcase
  endfunction

  // Mostly well-formed files with random content, some noise and truncation
  task automatic random_file();
    logic [15:0] se;
    logic [63:0] mant;
    int          keep;
    case ($urandom_range(0, 9))
      0: put_noise($urandom_range(1, 24));
      1: begin
        put_header(TAG_FORM, $urandom_range(0, 1) ? 32'($urandom) : TAG_AIFF);
        put_noise($urandom_range(1, 16));
      end
      2, 3: begin
        // header and COMM only: cheap rate and field coverage
        put_header(TAG_FORM, TAG_AIFF);
        pick_rate(se, mant);
        put_comm(COMM_MIN, pick_channels(), pick_bits(), se, mant);
      end
      default: begin
        put_header(TAG_FORM, TAG_AIFF);
        if ($urandom_range(0, 2) == 0) put_other($urandom_range(0, 5));
        if ($urandom_range(0, 9) != 0) begin
          pick_rate(se, mant);
          put_comm(($urandom_range(0, 3) == 0) ? $urandom_range(10, 24) : COMM_MIN,
                   pick_channels(), pick_bits(), se, mant);
        end
        repeat ($urandom_range(1, 2)) put_ssnd($urandom_range(0, 3), $urandom_range(0, 17));
        if ($urandom_range(0, 3) == 0) put_other($urandom_range(0, 3));
      end
    endcase
    keep = file_bytes.size();
    if ($urandom_range(0, 5) == 0) keep = $urandom_range(1, keep);
    send_file(keep);
  endtask

  // Stimulus
  initial begin
    logic [15:0] se_cases [7];
    logic [63:0] mant_cases [7];
    int          random_start;

    // 44100, 1.5, 2.5, negative, zero mantissa, saturation, exact left shift
    se_cases   = '{16'h400E, 16'h3FFF, 16'h4000, 16'hC00E, 16'h7FFF, 16'h401E, 16'h4043};
    mant_cases = '{64'hAC44_0000_0000_0000, 64'hC000_0000_0000_0000, 64'hA000_0000_0000_0000,
                   64'hAC44_0000_0000_0000, 64'h0, 64'h8000_0000_0000_0000, 64'h1};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // bad FORM tag, bad form type, file cut inside the header
    put_header(32'h464F5258, TAG_AIFF);
    send_file(6);
    put_header(TAG_FORM, 32'h41494643);
    put_comm(COMM_MIN, 16'd2, 16'd16, se_cases[0], mant_cases[0]);
    send_file(file_bytes.size());
    put_header(TAG_FORM, TAG_AIFF);
    send_file(7);

    // rate corner cases
    for (int k = 0; k < 7; k++) begin
      put_header(TAG_FORM, TAG_AIFF);
      put_comm(COMM_MIN, 16'd1, 16'd16, se_cases[k], mant_cases[k]);
      send_file(file_bytes.size());
    end

    // empty and odd chunks, padded COMM, lone byte, SSND without data
    put_header(TAG_FORM, TAG_AIFF);
    put_other(0);
    put_other(3);
    put_comm(19, 16'd2, 16'd16, se_cases[0], mant_cases[0]);
    put_ssnd(2, 5);
    put_ssnd(3, 0);
    put_other(1);
    send_file(file_bytes.size());

    // short COMM commits nothing
    put_header(TAG_FORM, TAG_AIFF);
    put_comm(10, 16'd2, 16'd16, se_cases[0], mant_cases[0]);
    put_ssnd(0, 6);
    send_file(file_bytes.size());

    // negative channels, 8 bits, last chunk holds a lone byte
    put_header(TAG_FORM, TAG_AIFF);
    put_comm(COMM_MIN, 16'hFFFF, 16'd8, se_cases[0], mant_cases[0]);
    put_ssnd(1, 4);
    put_ssnd(0, 1);
    send_file(file_bytes.size());

    // cut inside an SSND body, then inside a chunk header
    put_header(TAG_FORM, TAG_AIFF);
    put_comm(COMM_MIN, 16'd2, 16'd16, se_cases[0], mant_cases[0]);
    put_ssnd(0, 20);
    send_file(file_bytes.size() - 7);
    put_header(TAG_FORM, TAG_AIFF);
    put_other(4);
    send_file(17);

    // long receiver hold-off while samples keep coming: queue fills, input stalls
    calm = 1'b1;
    hold_request = 1'b1;
    put_header(TAG_FORM, TAG_AIFF);
    put_comm(COMM_MIN, 16'd2, 16'd16, se_cases[0], mant_cases[0]);
    put_ssnd(0, 128);
    send_file(file_bytes.size());
    calm = 1'b0;

    // random files, idling switched off towards the end
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      if (bytes_sent - random_start >= QUIET_AFTER) quiet = 1'b1;
      random_file();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (open_results == 0);
    repeat (16) @(posedge clk);

    $display("Covered %0d files and %0d bytes, %0d samples checked.",
             files_seen, bytes_sent, samples_seen);
    $display("Bad headers, cut files, padding, short COMM, rate corners, backpressure.");
    if (fail_count == 0 && open_results == 0) begin
      $display("PASS aiff_stream_parser");
    end else begin
      $display("FAIL aiff_stream_parser");
    end
    $finish;
  end

endmodule
